// File: rtl/vqncs_pkg.sv
package vqncs_pkg;

	// Field widths of the item and result formats.
	localparam int SAMPLE_W   = 16;
	localparam int IN_SAMPLES = 4;
	localparam int INDEX_W    = 8;
	localparam int DIST_W     = 34;
	localparam int SIZE_W     = 9;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register indexes, taken from the word address bits of paddr.
	localparam logic REG_CODEBOOK_SIZE = 1'b0;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	// Item kinds.
	localparam logic KIND_LOAD     = 1'b0;
	localparam logic KIND_QUANTIZE = 1'b1;

	typedef struct packed {
		logic                       kind;
		logic [INDEX_W-1:0]         entry_index;
		logic signed [SAMPLE_W-1:0] sample_0;
		logic signed [SAMPLE_W-1:0] sample_1;
		logic signed [SAMPLE_W-1:0] sample_2;
		logic signed [SAMPLE_W-1:0] sample_3;
	} item_t;

	typedef struct packed {
		logic [INDEX_W-1:0]         best_index;
		logic [DIST_W-1:0]          best_distance;
		logic signed [SAMPLE_W-1:0] recon_0;
		logic signed [SAMPLE_W-1:0] recon_1;
		logic signed [SAMPLE_W-1:0] recon_2;
		logic signed [SAMPLE_W-1:0] recon_3;
	} result_t;

endpackage

// File: rtl/vqncs_ram.sv
module vqncs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/vq_nearest_codeword_search.sv
// Nearest-codeword vector quantizer. A load item writes one codeword into the
// codebook RAM and produces no result. A quantize item walks codewords 0 to
// N-1 (N is codebook_size, 0 taken as 1 and clamped to CODEBOOK_DEPTH) and
// returns the index of the nearest codeword in squared Euclidean distance,
// lowest index on ties, its samples and the exact distance. One
// subtract-square-accumulate unit handles one vector element per cycle, so a
// quantize item holds the block through the search, the pipeline drain, the
// row readback and the result hand-off; the input is stalled meanwhile. A
// finished result waits in an output register, and the next item may be
// accepted while it waits. Codewords that were never loaded must not be
// searched.
module vq_nearest_codeword_search #(
	parameter int CODEBOOK_DEPTH = 256,
	parameter int VECTOR_LENGTH  = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Item channel
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  vqncs_pkg::item_t                     item,
	// Result channel
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output vqncs_pkg::result_t                   result,
	// Configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [vqncs_pkg::PADDR_W-1:0]        paddr,
	input  logic [vqncs_pkg::PDATA_W-1:0]        pwdata,
	output logic [vqncs_pkg::PDATA_W-1:0]        prdata,
	output logic                                 pready
);

	import vqncs_pkg::*;

	localparam int IDX_W   = (CODEBOOK_DEPTH > 1) ? $clog2(CODEBOOK_DEPTH) : 1;
	localparam int EL_W    = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
	localparam int ROW_W   = VECTOR_LENGTH * SAMPLE_W;
	localparam int DIFF_W  = SAMPLE_W + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int ACC_W   = DIST_W + $clog2(VECTOR_LENGTH);
	localparam int CMP_W   = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DRAIN,
		ST_FETCH,
		ST_DONE
	} state_t;

	// Tag that travels with each element step down the distance pipeline.
	typedef struct packed {
		logic             first;
		logic             last;
		logic [IDX_W-1:0] idx;
	} step_tag_t;

	state_t                    state_q;
	logic [SIZE_W-1:0]         size_q;
	logic [IDX_W-1:0]          idx_q;
	logic [EL_W-1:0]           elem_q;
	logic signed [SAMPLE_W-1:0] vec_q [VECTOR_LENGTH];

	logic                      v_s1, v_s2, v_s3, v_s4;
	step_tag_t                 tag_s1, tag_s2, tag_s3;
	logic [EL_W-1:0]           elem_s1;
	logic signed [DIFF_W-1:0]  diff_s2;
	logic [SQ_W-1:0]           sq_s3;
	logic [ACC_W-1:0]          acc_q;
	logic [ACC_W-1:0]          cand_s4;
	logic [IDX_W-1:0]          idx_s4;
	logic [ACC_W-1:0]          best_dist_q;
	logic [IDX_W-1:0]          best_idx_q;

	logic                      result_valid_q;
	result_t                   result_q;

	logic signed [SAMPLE_W-1:0] in_samp [IN_SAMPLES];
	logic signed [SAMPLE_W-1:0] row_elem [VECTOR_LENGTH];
	logic signed [SAMPLE_W-1:0] recon [IN_SAMPLES];
	logic [ROW_W-1:0]          wdata;
	logic [ROW_W-1:0]          rdata;
	logic [IDX_W-1:0]          raddr;
	logic                      ram_we;
	logic                      item_xfer;
	logic                      result_xfer;
	logic                      result_load;
	logic                      cfg_write;
	logic                      last_elem;
	logic [IDX_W-1:0]          last_idx;
	logic                      pipe_busy;
	logic signed [DIFF_W-1:0]  diff_c;
	logic signed [SQ_W-1:0]    prod_c;
	logic [ACC_W-1:0]          sum_c;
	logic                      better_c;

	assign item_xfer   = item_valid && !item_stall;
	assign result_xfer = result_valid_q && !result_stall;
	assign item_stall  = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Configuration register; reads return the register of the addressed word.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_CODEBOOK_SIZE);
	assign prdata    = (paddr[PADDR_W-1] == REG_CODEBOOK_SIZE) ?
		PDATA_W'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_write) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	// Index of the last codeword searched, after clamping the size.
	always_comb begin
		if (size_q == '0) begin
			last_idx = '0;
		end else if (CMP_W'(size_q) > CMP_W'(CODEBOOK_DEPTH)) begin
			last_idx = IDX_W'(CODEBOOK_DEPTH - 1);
		end else begin
			last_idx = IDX_W'(size_q - SIZE_W'(1));
		end
	end

	assign last_elem = (elem_q == EL_W'(VECTOR_LENGTH - 1));

	// Input samples as an array; elements past the fourth read as zero.
	assign in_samp[0] = item.sample_0;
	assign in_samp[1] = item.sample_1;
	assign in_samp[2] = item.sample_2;
	assign in_samp[3] = item.sample_3;

	for (genvar j = 0; j < VECTOR_LENGTH; j++) begin : g_row
		if (j < IN_SAMPLES) begin : g_in
			assign wdata[j*SAMPLE_W +: SAMPLE_W] = in_samp[j];
		end else begin : g_zero
			assign wdata[j*SAMPLE_W +: SAMPLE_W] = '0;
		end
		assign row_elem[j] = rdata[j*SAMPLE_W +: SAMPLE_W];
	end

	for (genvar j = 0; j < IN_SAMPLES; j++) begin : g_recon
		if (j < VECTOR_LENGTH) begin : g_used
			assign recon[j] = row_elem[j];
		end else begin : g_unused
			assign recon[j] = '0;
		end
	end

	// Codebook RAM: loads write on the item transfer, the search and the final readback read rows.
	assign ram_we = item_xfer && (item.kind == KIND_LOAD) &&
		(CMP_W'(item.entry_index) < CMP_W'(CODEBOOK_DEPTH));
	assign raddr  = (state_q == ST_FETCH || state_q == ST_DONE) ? best_idx_q : idx_q;

	vqncs_ram #(
		.WIDTH (ROW_W),
		.DEPTH (CODEBOOK_DEPTH)
	) u_codebook (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_W'(item.entry_index)),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sequencer and result register.
	assign pipe_busy   = v_s1 || v_s2 || v_s3 || v_s4;
	assign result_load = (state_q == ST_DONE) && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= '0;
			elem_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (result_xfer) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_xfer && item.kind == KIND_QUANTIZE) begin
						idx_q   <= '0;
						elem_q  <= '0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (last_elem) begin
						elem_q <= '0;
						if (idx_q == last_idx) begin
							state_q <= ST_DRAIN;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end else begin
						elem_q <= elem_q + EL_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (result_load) begin
						result_q.best_index    <= INDEX_W'(best_idx_q);
						result_q.best_distance <= best_dist_q[DIST_W-1:0];
						result_q.recon_0       <= recon[0];
						result_q.recon_1       <= recon[1];
						result_q.recon_2       <= recon[2];
						result_q.recon_3       <= recon[3];
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The quantize vector is held for the whole search.
	always_ff @(posedge clk) begin
		if (item_xfer && item.kind == KIND_QUANTIZE) begin
			for (int j = 0; j < VECTOR_LENGTH; j++) begin
				vec_q[j] <= (j < IN_SAMPLES) ? in_samp[j] : '0;
			end
		end
	end

	// Valid bits of the distance pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SEARCH);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && tag_s3.last;
		end
	end

	// Shared datapath: subtract, square, accumulate, then compare per codeword.
	assign diff_c   = DIFF_W'(row_elem[elem_s1]) - DIFF_W'(vec_q[elem_s1]);
	assign prod_c   = diff_s2 * diff_s2;
	assign sum_c    = (tag_s3.first ? '0 : acc_q) + ACC_W'(sq_s3);
	assign better_c = (idx_s4 == '0) || (cand_s4 < best_dist_q);

	always_ff @(posedge clk) begin
		elem_s1       <= elem_q;
		tag_s1.first  <= (elem_q == '0);
		tag_s1.last   <= last_elem;
		tag_s1.idx    <= idx_q;

		tag_s2  <= tag_s1;
		diff_s2 <= diff_c;

		tag_s3 <= tag_s2;
		sq_s3  <= SQ_W'(unsigned'(prod_c));

		if (v_s3) begin
			acc_q <= sum_c;
		end
		cand_s4 <= sum_c;
		idx_s4  <= tag_s3.idx;

		if (v_s4 && better_c) begin
			best_dist_q <= cand_s4;
			best_idx_q  <= idx_s4;
		end
	end

`ifndef NO_ASSERTIONS
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_fetch_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> !pipe_busy)
		else $error("readback started with the pipeline still busy");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (idx_q <= last_idx))
		else $error("search index past the last codeword");

	a_best_update: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && better_c) |=> (best_idx_q == $past(idx_s4)))
		else $error("best index not taken from a nearer candidate");

	a_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pipe_busy)
		else $error("distance pipeline active while idle");
`endif

endmodule
